/* sv/lpsd_pkg.sv */
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants for the length-prefixed string deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

  localparam int LEN_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic [7:0] SEPARATOR_RESET = 8'h40;  // '@'
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FIELD = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;
  localparam logic [1:0] ERR_CUT   = 2'd3;

  // Command handed from the parser to the output stage.
  typedef enum logic [2:0] {
    OP_PASS      = 3'd0,  // payload byte, string continues
    OP_PASS_LAST = 3'd1,  // last payload byte of a string
    OP_PASS_CUT  = 3'd2,  // payload byte, stream ended inside the frame
    OP_EMPTY     = 3'd3,  // zero-length string
    OP_ERR_FIELD = 3'd4,  // bad length field
    OP_ERR_OVF   = 3'd5,  // length too large
    OP_ERR_CUT   = 3'd6   // stream ended inside the frame
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/lpsd_front.sv */
// ----------------------------------------------------------------------------
// lpsd_front
// Byte parser: gathers the decimal length, counts payload bytes and issues
// one command for every byte that yields a result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_front
  import lpsd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            push,
  output cmd_t            cmd
);

  localparam int EXT_BITS = LEN_BITS + 4;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_PAY  = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  phase_t              phase, phase_next;
  logic [LEN_BITS-1:0] length_acc, length_acc_next;
  logic                digit_seen, digit_seen_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]          separator;

  logic                accept;
  logic                emit;
  op_t                 op;
  logic                is_digit;
  logic [EXT_BITS-1:0] acc_ext;
  logic [EXT_BITS-1:0] acc_times10;
  logic [LEN_BITS-1:0] left_dec;

  assign accept   = in_valid && in_ready;
  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign acc_ext  = {4'b0, length_acc};
  assign acc_times10 = (acc_ext << 3) + (acc_ext << 1) + {{LEN_BITS{1'b0}}, in_byte[3:0]};
  assign left_dec = bytes_left - {{(LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_next      = phase;
    length_acc_next = length_acc;
    digit_seen_next = digit_seen;
    bytes_left_next = bytes_left;
    emit            = 1'b0;
    op              = OP_PASS;
    unique case (phase)
      PH_DROP: begin
        if (end_of_input) begin
          phase_next      = PH_LEN;
          length_acc_next = '0;
          digit_seen_next = 1'b0;
          bytes_left_next = '0;
        end
      end
      PH_PAY: begin
        emit            = 1'b1;
        bytes_left_next = left_dec;
        if (left_dec == '0 || end_of_input) begin
          op              = (left_dec == '0) ? OP_PASS_LAST : OP_PASS_CUT;
          phase_next      = PH_LEN;
          length_acc_next = '0;
          digit_seen_next = 1'b0;
          bytes_left_next = '0;
        end
      end
      default: begin
        emit = 1'b1;
        priority if (in_byte == separator) begin
          if (!digit_seen) begin
            op = OP_ERR_FIELD;
          end else if (length_acc == '0) begin
            op = OP_EMPTY;
          end else if (end_of_input) begin
            op = OP_ERR_CUT;
          end else begin
            emit = 1'b0;
          end
        end else if (is_digit) begin
          if (acc_times10[EXT_BITS-1:LEN_BITS] != '0) begin
            op = OP_ERR_OVF;
          end else if (end_of_input) begin
            op = OP_ERR_CUT;
          end else begin
            emit = 1'b0;
          end
        end else begin
          op = OP_ERR_FIELD;
        end

        if (!emit) begin
          if (in_byte == separator) begin
            // advance to payload
            phase_next      = PH_PAY;
            bytes_left_next = length_acc;
            length_acc_next = '0;
            digit_seen_next = 1'b0;
          end else begin
            length_acc_next = acc_times10[LEN_BITS-1:0];
            digit_seen_next = 1'b1;
          end
        end else if (end_of_input || op == OP_EMPTY) begin
          phase_next      = PH_LEN;
          length_acc_next = '0;
          digit_seen_next = 1'b0;
          bytes_left_next = '0;
        end else begin
          // drop until end of input
          phase_next = PH_DROP;
        end
      end
    endcase
  end

  assign push     = accept && emit;
  assign cmd.op   = op;
  assign cmd.data = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN;
      length_acc <= '0;
      digit_seen <= 1'b0;
      bytes_left <= '0;
      separator  <= SEPARATOR_RESET;
    end else begin
      if (cfg_wr_en) begin
        separator <= cfg_wr_data;
      end
      if (accept) begin
        phase      <= phase_next;
        length_acc <= length_acc_next;
        digit_seen <= digit_seen_next;
        bytes_left <= bytes_left_next;
      end
    end
  end

  a_pay_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  a_len_no_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEN) |-> (bytes_left == '0))
    else $error("length phase with stale byte count");

endmodule

`default_nettype wire

/* sv/lpsd_queue.sv */
// ----------------------------------------------------------------------------
// lpsd_queue
// Short command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_queue
  import lpsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      q_valid,
  input  wire logic pop,
  output cmd_t      q_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* sv/lpsd_back.sv */
// ----------------------------------------------------------------------------
// lpsd_back
// Output stage: decodes queued commands into result fields and holds them
// in a register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_back
  import lpsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_string,
  output logic       empty_string,
  output logic [1:0] error_code
);

  logic [7:0] byte_next;
  logic       has_next, eos_next, empty_next;
  logic [1:0] err_next;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    byte_next  = 8'h00;
    has_next   = 1'b0;
    eos_next   = 1'b0;
    empty_next = 1'b0;
    err_next   = ERR_OK;
    unique case (q_cmd.op)
      OP_PASS: begin
        byte_next = q_cmd.data;
        has_next  = 1'b1;
      end
      OP_PASS_LAST: begin
        byte_next = q_cmd.data;
        has_next  = 1'b1;
        eos_next  = 1'b1;
      end
      OP_PASS_CUT: begin
        byte_next = q_cmd.data;
        has_next  = 1'b1;
        err_next  = ERR_CUT;
      end
      OP_EMPTY: begin
        eos_next   = 1'b1;
        empty_next = 1'b1;
      end
      OP_ERR_FIELD: err_next = ERR_FIELD;
      OP_ERR_OVF:   err_next = ERR_OVF;
      OP_ERR_CUT:   err_next = ERR_CUT;
      default:      err_next = ERR_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte      <= byte_next;
      has_byte      <= has_next;
      end_of_string <= eos_next;
      empty_string  <= empty_next;
      error_code    <= err_next;
    end
  end

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (out_byte == 8'h00))
    else $error("out_byte not cleared without payload");

  a_empty_eos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_string) |-> (end_of_string && !has_byte))
    else $error("empty string marker malformed");

endmodule

`default_nettype wire

/* sv/length_prefixed_string_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer
// Decodes frames of the form <decimal length><separator><payload bytes>.
// ----------------------------------------------------------------------------
// Takes one byte per cycle whenever in_ready is high, with no gaps between
// frames. The parser updates its length and byte counters for each accepted
// byte; a request is accepted whenever the two-entry command queue has room,
// and a result passes from the command queue into the output register. A
// stalled output fills the queue after two more result-bearing bytes, then
// in_ready drops. All dropped bytes after an error produce no result, nor do
// length digits and the separator of a nonzero length unless they overflow
// or end the stream. The separator register (default '@') is written through
// cfg_wr_en/cfg_wr_data and must only be changed while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_string_deframer
  import lpsd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            end_of_string,
  output logic            empty_string,
  output logic [1:0]      error_code
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic q_valid;
  logic pop;
  cmd_t q_cmd;

  // Hold off requests only when the queue cannot take another command.
  assign in_ready = !full;

  // Parse the byte stream and issue commands.
  lpsd_front #(
    .LEN_BITS(LEN_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Decouple the parser from output backpressure.
  lpsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_cmd    (q_cmd)
  );

  // Format results and hold them until taken.
  lpsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .has_byte      (has_byte),
    .end_of_string (end_of_string),
    .empty_string  (empty_string),
    .error_code    (error_code)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed string deframer. A scoreboard
// decodes every accepted request byte on its own and queues the result the
// block should give. Each result taken from the output is compared field by
// field. Directed streams cover the corner cases. Random streams of mostly
// well-formed frames follow, under several separator settings. Both sides of
// the block idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------

module testbench;
  import lpsd_pkg::*;

  localparam int unsigned LEN_MAX = (1 << LEN_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES   = 8;     // output register plus queue, with margin
  localparam int WATCHDOG_LIMIT  = 2000;  // well above the long output stall
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 170;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } parse_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       empty_string;
    logic [1:0] error_code;
  } deframed_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } stream_item_t;

  // Mirrors the parser: one call per accepted byte. It queues the result the
  // byte should produce, if it produces one.
  class deframe_scoreboard;
    logic [7:0]   separator;
    parse_state_t state;
    logic [15:0]  length_acc;
    bit           digit_seen;
    logic [15:0]  bytes_left;
    deframed_t    pending_results[$];
    int           fail_count;

    function new();
      separator  = SEPARATOR_RESET;
      fail_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      state      = PH_LENGTH;
      length_acc = '0;
      digit_seen = 1'b0;
      bytes_left = '0;
    endfunction

    function void set_separator(logic [7:0] value);
      separator = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void accept_byte(logic [7:0] b, bit eoi);
      deframed_t   r;
      bit          produce;
      int unsigned next_len;
      r = '0;
      produce = 1'b0;
      case (state)
        PH_DROP: begin
          if (eoi) clear_frame();
        end
        PH_PAYLOAD: begin
          bytes_left = bytes_left - 16'd1;
          produce = 1'b1;
          r.out_byte = b;
          r.has_byte = 1'b1;
          if (bytes_left == 0) begin
            r.end_of_string = 1'b1;
            clear_frame();
          end else if (eoi) begin
            r.error_code = ERR_CUT;
            clear_frame();
          end
        end
        default: begin
          produce = 1'b1;
          // The separator test wins over the digit test.
          if (b == separator) begin
            if (!digit_seen) begin
              r.error_code = ERR_FIELD;
            end else if (length_acc == 0) begin
              r.end_of_string = 1'b1;
              r.empty_string  = 1'b1;
            end else if (eoi) begin
              r.error_code = ERR_CUT;
            end else begin
              bytes_left = length_acc;
              length_acc = '0;
              digit_seen = 1'b0;
              state = PH_PAYLOAD;
              produce = 1'b0;
            end
          end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            next_len = length_acc * 10 + (b - CHAR_ZERO);
            if (next_len > LEN_MAX) begin
              r.error_code = ERR_OVF;
            end else begin
              length_acc = next_len[15:0];
              digit_seen = 1'b1;
              if (eoi) r.error_code = ERR_CUT;
              else produce = 1'b0;
            end
          end else begin
            r.error_code = ERR_FIELD;
          end
          // An error drops the rest of the stream; anything else starts over.
          if (produce) begin
            if (r.error_code != ERR_OK && !eoi) state = PH_DROP;
            else clear_frame();
          end
        end
      endcase
      if (produce) pending_results = {pending_results, r};
    endfunction

    function void check_output(deframed_t got);
      deframed_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: out_byte %0h error_code %0d",
               got.out_byte, got.error_code);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %0b, actual %0b", want.has_byte, got.has_byte);
        fail_count++;
      end
      if (got.end_of_string !== want.end_of_string) begin
        $error("end_of_string: expected %0b, actual %0b",
               want.end_of_string, got.end_of_string);
        fail_count++;
      end
      if (got.empty_string !== want.empty_string) begin
        $error("empty_string: expected %0b, actual %0b",
               want.empty_string, got.empty_string);
        fail_count++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
        fail_count++;
      end
    endfunction
  endclass

  // Every input starts at a known value; reset is high from time zero.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_string;
  logic       empty_string;
  logic [1:0] error_code;

  deframe_scoreboard sb = new();
  stream_item_t      byte_stream[$];
  int                burst_left = 0;
  bit                hold_off_req = 1'b0;
  int                idle_cycles = 0;
  logic [7:0]        sep_plan [6] = '{8'h00, 8'hFF, 8'h35, 8'h00, 8'h00, SEPARATOR_RESET};

  always #5 clk = ~clk;

  length_prefixed_string_deframer #(
    .LEN_BITS(LEN_BITS_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .end_of_string(end_of_string),
    .empty_string (empty_string),
    .error_code   (error_code)
  );

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b);
    stream_item_t item;
    item.data = b;
    item.eoi  = 1'b0;
    byte_stream = {byte_stream, item};
  endtask

  // Flag the newest byte as the end of the encoded stream.
  task automatic mark_end();
    stream_item_t item;
    item = byte_stream.pop_back();
    item.eoi = 1'b1;
    byte_stream = {byte_stream, item};
  endtask

  // Append the decimal digits of a length, most significant first.
  task automatic push_length(int unsigned len, bit lead_zero);
    logic [7:0]  digits[$];
    int unsigned rest;
    rest = len;
    do begin
      digits.push_front(CHAR_ZERO + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    if (lead_zero) digits.push_front(CHAR_ZERO);
    foreach (digits[i]) push_byte(digits[i]);
  endtask

  // Draw a frame length, mostly short. Where the separator is itself a
  // digit, retry up to 20 times until the length's digits steer clear of it.
  function automatic int unsigned pick_length(logic [7:0] sep);
    int unsigned len;
    int unsigned rest;
    bit          clash;
    len = 0;
    for (int t = 0; t < 20; t++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
      rest = len;
      clash = 1'b0;
      do begin
        if (CHAR_ZERO + 8'(rest % 10) == sep) clash = 1'b1;
        rest = rest / 10;
      end while (rest != 0);
      if (!clash) return len;
    end
    return len;
  endfunction

  // One stream: a few frames, mostly well formed, some broken, ending with
  // the end-of-input flag on its last byte.
  task automatic append_stream(logic [7:0] sep);
    int          frames;
    int          kind;
    int unsigned len;
    frames = $urandom_range(1, 4);
    for (int f = 0; f < frames; f++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        len = pick_length(sep);
        push_length(len, sep != CHAR_ZERO && $urandom_range(0, 7) == 0);
        push_byte(sep);
        repeat (len) push_byte(8'($urandom_range(0, 255)));
      end else if (kind < 86) begin
        // raw noise, mostly a bad length field
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        push_length($urandom_range(LEN_MAX + 1, 199999), 1'b0);
      end else if (kind < 94) begin
        push_byte(sep);
      end else begin
        // cut short inside the digits or inside the payload
        len = pick_length(sep) + 1;
        push_length(len, 1'b0);
        if ($urandom_range(0, 3) != 0) begin
          push_byte(sep);
          repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom_range(0, 255)));
        end
        break;
      end
    end
    mark_end();
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer every queued byte as a request, in bursts with random gaps.
  // Hold valid and payload until the request is taken.
  task automatic send_stream();
    stream_item_t item;
    int           gap;
    while (byte_stream.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      item = byte_stream.pop_front();
      in_valid     <= 1'b1;
      in_byte      <= item.data;
      end_of_input <= item.eoi;
      do @(posedge clk); while (!in_ready);
      sb.accept_byte(item.data, item.eoi);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_separator(value);
  endtask

  // Receiver: check each accepted result, then pick the next ready value.
  // Stall in modes of random length; on request, hold off for a long stretch.
  initial begin : receiver
    deframed_t got;
    int        mode;
    int        mode_left;
    int        hold_left;
    int        tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.out_byte      = out_byte;
        got.has_byte      = has_byte;
        got.end_of_string = end_of_string;
        got.empty_string  = empty_string;
        got.error_code    = error_code;
        sb.check_output(got);
      end
      tick++;
      if (hold_left == 0 && hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  // Watchdog: give up after too many cycles with no request or result moving.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [7:0] sep;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed streams under the reset separator.
    // Empty string, a two-byte string at the byte extremes, then a bad
    // length field and a dropped tail.
    push_length(0, 1'b0);
    push_byte(SEPARATOR_RESET);
    push_length(2, 1'b0);
    push_byte(SEPARATOR_RESET);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h41);
    push_byte(8'h37);
    mark_end();
    // Largest legal length, cut inside the length field.
    push_length(LEN_MAX, 1'b0);
    mark_end();
    // One past the largest length, then a dropped byte.
    push_length(LEN_MAX + 1, 1'b0);
    push_byte(8'h31);
    mark_end();
    // Separator with no digits, on the last byte.
    push_byte(SEPARATOR_RESET);
    mark_end();
    // Stream ends right after a nonzero length's separator.
    push_length(1, 1'b0);
    push_byte(SEPARATOR_RESET);
    mark_end();
    // Stream ends inside the payload.
    push_length(3, 1'b0);
    push_byte(SEPARATOR_RESET);
    push_byte(8'h61);
    push_byte(8'h62);
    mark_end();
    // Stream ends on the last payload byte.
    push_length(1, 1'b0);
    push_byte(SEPARATOR_RESET);
    push_byte(8'h7A);
    mark_end();
    send_stream();
    wait_drained();

    // Random phases: extremes, a digit separator, random values, default.
    for (int p = 0; p < 6; p++) begin
      sep = (p == 3 || p == 4) ? 8'($urandom_range(0, 255)) : sep_plan[p];
      write_separator(sep);
      while (byte_stream.size() < PHASE_ITEMS) append_stream(sep);
      // Back up the block once while the sender keeps offering.
      if (p == 1) hold_off_req = 1'b1;
      send_stream();
      wait_drained();
    end

    if (sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lpsd_pkg.sv
sv/lpsd_front.sv
sv/lpsd_queue.sv
sv/lpsd_back.sv
sv/length_prefixed_string_deframer.sv
tb/testbench.sv
